[sv/tpra_pkg.sv]
package tpra_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int MIP_LEVELS_DEF    = 16;
   localparam int KEY_W             = 44;
   localparam int PIN_DEPTH         = 255;
   localparam logic [7:0] NO_TEXTURE = 8'hFF;

   localparam logic [1:0] ACT_LOAD_PIN = 2'd0;
   localparam logic [1:0] ACT_FEEDBACK = 2'd1;
   localparam logic [1:0] ACT_READ     = 2'd2;
   localparam logic [1:0] ACT_CLEAR    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ID,
      ST_PIN,
      ST_SCAN,
      ST_CMP,
      ST_RDADDR,
      ST_RDWAIT
   } state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  texture_slot;
      logic [4:0]  pinned_mip;
      logic [63:0] feedback_word;
      logic [7:0]  read_index;
   } req_type;

   typedef struct packed {
      logic        overflow;
      logic [8:0]  entries_used;
      logic        entry_valid;
      logic [7:0]  entry_texture;
      logic [3:0]  entry_mip;
      logic [15:0] entry_x;
      logic [15:0] entry_y;
      logic [31:0] entry_count;
   } rsp_type;

endpackage

[sv/tpra_pinned.sv]
module tpra_pinned import tpra_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  logic [7:0] wr_addr,
   input  logic [4:0] wr_data,
   input  logic [7:0] rd_addr,
   output logic [4:0] rd_data
);
   logic [4:0]           mem [PIN_DEPTH];
   logic [PIN_DEPTH-1:0] valid_ff;
   logic [4:0]           data_ff;
   logic                 hit_ff;

   // valid bits stand in for the all-zero reset of the array
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en && wr_addr != NO_TEXTURE) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_addr != NO_TEXTURE) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_addr != NO_TEXTURE) begin
         data_ff <= mem[rd_addr];
         hit_ff  <= valid_ff[rd_addr];
      end else begin
         data_ff <= '0;
         hit_ff  <= 1'b0;
      end
   end

   assign rd_data = hit_ff ? data_ff : 5'd0;
endmodule

[sv/tpra_table.sv]
module tpra_table import tpra_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
   input  logic [KEY_W-1:0]                 wr_key,
   input  logic [31:0]                      wr_count,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   output logic [KEY_W-1:0]                 rd_key,
   output logic [31:0]                      rd_count
);
   logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
   logic [31:0]      cnt_mem [TABLE_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         cnt_mem[wr_addr] <= wr_count;
      end
      rd_key   <= key_mem[rd_addr];
      rd_count <= cnt_mem[rd_addr];
   end
endmodule

[sv/texture_page_request_aggregator_top.sv]
// Texture page request aggregator.
// Input channel: an item (req_data) transfers on a rising edge with start high
// and busy low. Action selects: load a pinned mip, fold in a feedback word,
// read back a table slot, or clear the request table.
// Result channel: exactly one result per item, shown on rsp_data for a single
// cycle with rsp_valid high. The receiver cannot stall; every result is taken.
// Steps: load pinned mip and clear go straight to the result state; a slot
// read passes a read-address state first. A feedback word takes its ids in
// turn (a skipped id costs only the id step); for each mip touched, the walk
// is a linear search over the key memory through its single read port, one
// slot read in the scan state and its compare in the compare state after it,
// and a new slot is written when no slot matched. busy stays high throughout;
// the next item may transfer in the cycle the result strobe is shown.
// Reset: pinned mips read as zero (valid bits clear at once), the request
// table is empty. No clearing pass is needed; slot contents are only read
// below the fill count.
module texture_page_request_aggregator_top import tpra_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int MIP_LEVELS    = MIP_LEVELS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = AW + 1;                 // fill count holds TABLE_ENTRIES
   localparam int XW = (CW > 8) ? CW : 8;      // scan index, also covers read_index

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [1:0]       k_ff, k_in;               // id number within the word
   logic [7:0]       tex_ff, tex_in;
   logic [4:0]       pin_ff, pin_in;
   logic [4:0]       mip_ff, mip_in;
   logic [15:0]      x_ff, x_in, y_ff, y_in;
   logic [XW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    slots_ff, slots_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             pin_wr;
   logic [4:0]       pin_wdata, pin_rdata;
   logic [7:0]       id_sel;
   logic             tbl_wr;
   logic [AW-1:0]    tbl_waddr;
   logic [KEY_W-1:0] tbl_wkey, tbl_rkey, cur_key;
   logic [31:0]      tbl_wcnt, tbl_rcnt;
   logic [4:0]       mip_next;
   logic             accept;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      case (k_ff)
         2'd0:    id_sel = req_ff.feedback_word[47:40];
         2'd1:    id_sel = req_ff.feedback_word[63:56];
         2'd2:    id_sel = req_ff.feedback_word[55:48];
         default: id_sel = NO_TEXTURE;
      endcase
   end

   assign pin_wdata = (req_data.pinned_mip > 5'(MIP_LEVELS)) ? 5'(MIP_LEVELS)
                                                             : req_data.pinned_mip;
   assign pin_wr    = accept && req_data.action == ACT_LOAD_PIN;

   tpra_pinned u_pinned (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (pin_wr),
      .wr_addr (req_data.texture_slot),
      .wr_data (pin_wdata),
      .rd_addr (id_sel),
      .rd_data (pin_rdata)
   );

   tpra_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
      .clock    (clock),
      .wr_en    (tbl_wr),
      .wr_addr  (tbl_waddr),
      .wr_key   (tbl_wkey),
      .wr_count (tbl_wcnt),
      .rd_addr  (idx_ff[AW-1:0]),
      .rd_key   (tbl_rkey),
      .rd_count (tbl_rcnt)
   );

   assign cur_key  = {tex_ff, mip_ff[3:0], y_ff, x_ff};
   assign mip_next = mip_ff + 5'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slots_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slots_ff     <= slots_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      k_ff   <= k_in;
      tex_ff <= tex_in;
      pin_ff <= pin_in;
      mip_ff <= mip_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      idx_ff <= idx_in;
      ovf_ff <= ovf_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      k_in         = k_ff;
      tex_in       = tex_ff;
      pin_in       = pin_ff;
      mip_in       = mip_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      idx_in       = idx_ff;
      slots_in     = slots_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      tbl_wr       = 1'b0;
      tbl_waddr    = slots_ff[AW-1:0];
      tbl_wkey     = cur_key;
      tbl_wcnt     = 32'd1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               k_in   = 2'd0;
               ovf_in = 1'b0;
               idx_in = XW'(req_data.read_index);
               case (req_data.action)
                  ACT_FEEDBACK: state_in = ST_ID;
                  ACT_READ:     state_in = ST_RDADDR;
                  ACT_CLEAR: begin
                     slots_in = '0;
                     state_in = ST_RDWAIT;
                  end
                  default:      state_in = ST_RDWAIT;
               endcase
            end
         end
         ST_ID: begin
            if (k_ff == 2'd3) begin
               state_in = ST_RDWAIT;
            end else if (id_sel == NO_TEXTURE) begin
               k_in = k_ff + 2'd1;
            end else begin
               tex_in   = id_sel;
               state_in = ST_PIN;
            end
         end
         ST_PIN: begin
            // requested mip at or above the pinned mip: nothing for this id
            if (req_ff.feedback_word[39:32] >= {3'd0, pin_rdata}) begin
               k_in     = k_ff + 2'd1;
               state_in = ST_ID;
            end else begin
               pin_in   = pin_rdata;
               mip_in   = req_ff.feedback_word[36:32];
               x_in     = req_ff.feedback_word[15:0] >> req_ff.feedback_word[35:32];
               y_in     = req_ff.feedback_word[31:16] >> req_ff.feedback_word[35:32];
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff < XW'(slots_ff)) begin
               state_in = ST_CMP;
            end else if (slots_ff >= CW'(TABLE_ENTRIES)) begin
               // table full: drop, flag, end this id's walk
               ovf_in   = 1'b1;
               k_in     = k_ff + 2'd1;
               state_in = ST_ID;
            end else begin
               tbl_wr   = 1'b1;
               slots_in = slots_ff + CW'(1);
               if (mip_next >= pin_ff) begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_ID;
               end else begin
                  mip_in = mip_next;
                  x_in   = x_ff >> 1;
                  y_in   = y_ff >> 1;
                  idx_in = '0;
               end
            end
         end
         ST_CMP: begin
            if (tbl_rkey == cur_key) begin
               tbl_wr    = 1'b1;
               tbl_waddr = idx_ff[AW-1:0];
               tbl_wkey  = tbl_rkey;
               tbl_wcnt  = (tbl_rcnt == 32'hFFFF_FFFF) ? tbl_rcnt : tbl_rcnt + 32'd1;
               k_in      = k_ff + 2'd1;
               state_in  = ST_ID;
            end else begin
               idx_in   = idx_ff + XW'(1);
               state_in = ST_SCAN;
            end
         end
         ST_RDADDR: state_in = ST_RDWAIT;
         ST_RDWAIT: begin
            // final cycle of every item: build the result
            rsp_valid_in        = 1'b1;
            rsp_in              = '0;
            rsp_in.overflow     = ovf_ff;
            rsp_in.entries_used = 9'(slots_ff);
            if (req_ff.action == ACT_READ && idx_ff < XW'(slots_ff)) begin
               rsp_in.entry_valid   = 1'b1;
               rsp_in.entry_texture = tbl_rkey[43:36];
               rsp_in.entry_mip     = tbl_rkey[35:32];
               rsp_in.entry_y       = tbl_rkey[31:16];
               rsp_in.entry_x       = tbl_rkey[15:0];
               rsp_in.entry_count   = tbl_rcnt;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // one strobe per item, never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe repeated");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after transfer");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      slots_ff <= CW'(TABLE_ENTRIES))
      else $error("fill count beyond table size");

   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.entry_valid |-> rsp_data.entry_count == 32'd0)
      else $error("entry fields set on empty read");
endmodule

[test/tpra_checker.sv]
`timescale 1ns / 100ps
module tpra_checker import tpra_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);

   logic [4:0]  pin_mip [0:254];
   logic [43:0] page_key [0:255];
   logic [31:0] page_cnt [0:255];
   int          used;
   rsp_type     expected_rsps [$];

   assign pending = expected_rsps.size();

   // 1 new, 0 counted, -1 table full
   function automatic int bump_page(logic [43:0] key);
      int i;
      for (i = 0; i < used; i++) begin
         if (page_key[i] == key) begin
            if (page_cnt[i] != 32'hFFFF_FFFF) page_cnt[i]++;
            return 0;
         end
      end
      if (used >= 256) return -1;
      page_key[used] = key;
      page_cnt[used] = 32'd1;
      used++;
      return 1;
   endfunction

   function automatic bit walk_pages(logic [7:0] tex, logic [7:0] mip_in,
                                     logic [15:0] x_in, logic [15:0] y_in);
      int mip, pin, r;
      logic [15:0] x, y;
      pin = pin_mip[tex];
      mip = mip_in;
      if (mip >= pin) return 1'b0;
      x = x_in >> mip;
      y = y_in >> mip;
      forever begin
         r = bump_page({tex, mip[3:0], y, x});
         if (r < 0) return 1'b1;
         mip++;
         if (r == 0 || mip >= pin) return 1'b0;
         x = x >> 1;
         y = y >> 1;
      end
   endfunction

   function automatic rsp_type apply_request(req_type rq);
      rsp_type o;
      logic [7:0] ids [3];
      logic [43:0] k;
      int pm;
      o = '0;
      case (rq.action)
         ACT_LOAD_PIN: begin
            pm = (rq.pinned_mip > 16) ? 16 : rq.pinned_mip;
            if (rq.texture_slot != NO_TEXTURE) pin_mip[rq.texture_slot] = pm[4:0];
         end
         ACT_FEEDBACK: begin
            ids[0] = rq.feedback_word[47:40];
            ids[1] = rq.feedback_word[63:56];
            ids[2] = rq.feedback_word[55:48];
            for (int j = 0; j < 3; j++)
               if (ids[j] != NO_TEXTURE &&
                   walk_pages(ids[j], rq.feedback_word[39:32], rq.feedback_word[15:0],
                              rq.feedback_word[31:16]))
                  o.overflow = 1'b1;
         end
         ACT_READ: begin
            if (rq.read_index < used) begin
               k = page_key[rq.read_index];
               o.entry_valid   = 1'b1;
               o.entry_texture = k[43:36];
               o.entry_mip     = k[35:32];
               o.entry_y       = k[31:16];
               o.entry_x       = k[15:0];
               o.entry_count   = page_cnt[rq.read_index];
            end
         end
         default: used = 0;
      endcase
      o.entries_used = used[8:0];
      return o;
   endfunction

   task automatic cmp(string nm, longint unsigned e, longint unsigned a);
      if (e != a) begin
         $error("%s: expected 0x%0h, got 0x%0h", nm, e, a);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int i = 0; i < 255; i++) pin_mip[i] = '0;
         used = 0;
         fail_count = 0;
         expected_rsps.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $error("result with nothing expected");
               fail_count++;
            end else begin
               e = expected_rsps.pop_front();
               cmp("overflow", e.overflow, rsp_data.overflow);
               cmp("entries_used", e.entries_used, rsp_data.entries_used);
               cmp("entry_valid", e.entry_valid, rsp_data.entry_valid);
               cmp("entry_texture", e.entry_texture, rsp_data.entry_texture);
               cmp("entry_mip", e.entry_mip, rsp_data.entry_mip);
               cmp("entry_x", e.entry_x, rsp_data.entry_x);
               cmp("entry_y", e.entry_y, rsp_data.entry_y);
               cmp("entry_count", e.entry_count, rsp_data.entry_count);
            end
         end
         if (start && !busy) begin
            e = apply_request(req_data);
            expected_rsps = {expected_rsps, e};
         end
      end
   end

endmodule

[test/tb_texture_page_request_aggregator_top.sv]
`timescale 1ns / 100ps
module tb_texture_page_request_aggregator_top;
   import tpra_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      n_transfers = 0;

   always #2 clock = ~clock;

   texture_page_request_aggregator_top i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   tpra_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   // Small pools of textures and coordinates so words hit existing pages
   // and the table fills up now and then.
   function automatic logic [7:0] pick_tex();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return NO_TEXTURE;
      if (r == 1) return 8'($urandom_range(0, 254));
      return 8'($urandom_range(0, 5));
   endfunction

   function automatic req_type rand_request();
      req_type rq;
      int r;
      rq = '0;
      rq.texture_slot  = 8'($urandom);
      rq.pinned_mip    = 5'($urandom);
      rq.read_index    = 8'($urandom);
      rq.feedback_word = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 8) begin
         rq.action = ACT_LOAD_PIN;
         if ($urandom_range(0, 3) != 0) rq.texture_slot = pick_tex();
      end else if (r < 70) begin
         rq.action = ACT_FEEDBACK;
         if ($urandom_range(0, 4) != 0) begin
            rq.feedback_word[63:56] = pick_tex();
            rq.feedback_word[55:48] = pick_tex();
            rq.feedback_word[47:40] = pick_tex();
            rq.feedback_word[39:32] = 8'($urandom_range(0, 5));
            if ($urandom_range(0, 1)) begin
               rq.feedback_word[31:16] = 16'($urandom_range(0, 15)) << 10;
               rq.feedback_word[15:0]  = 16'($urandom_range(0, 15)) << 10;
            end
         end
      end else if (r < 97) begin
         rq.action = ACT_READ;
      end else begin
         rq.action = ACT_CLEAR;
      end
      return rq;
   endfunction

   // One transfer: hold start until busy is seen low mid-cycle, then the
   // next rising edge takes the item.
   task automatic send(req_type rq);
      start    <= 1'b1;
      req_data <= rq;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      n_transfers++;
   endtask

   task automatic idle(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic req_type pin_req(logic [7:0] tex, logic [4:0] pm);
      req_type rq;
      rq = '0;
      rq.action = ACT_LOAD_PIN;
      rq.texture_slot = tex;
      rq.pinned_mip = pm;
      return rq;
   endfunction

   function automatic req_type fb_req(logic [63:0] w);
      req_type rq;
      rq = '0;
      rq.action = ACT_FEEDBACK;
      rq.feedback_word = w;
      return rq;
   endfunction

   function automatic req_type rd_req(logic [7:0] idx);
      req_type rq;
      rq = '0;
      rq.action = ACT_READ;
      rq.read_index = idx;
      return rq;
   endfunction

   initial begin
      req_type rq;
      int burst;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: texture zero unpinned requests nothing; read of empty slot.
      send(fb_req({8'hFF, 8'hFF, 8'h00, 8'h00, 16'h1234, 16'h5678}));
      send(rd_req(8'd0));
      send(rd_req(8'hFF));
      // Pins: saturation above sixteen, slot 255 ignored, max field.
      send(pin_req(8'd0, 5'd31));
      send(pin_req(8'd1, 5'd4));
      send(pin_req(8'd254, 5'd16));
      send(pin_req(NO_TEXTURE, 5'd7));
      send(pin_req(8'd2, 5'd0));
      // Full walks, repeat hits, mip at or above pin.
      send(fb_req({8'h01, 8'hFE, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF}));
      send(fb_req({8'h01, 8'hFE, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF}));
      send(fb_req({8'h02, 8'h01, 8'hFF, 8'h04, 16'h0000, 16'h0000}));
      send(fb_req({8'hFF, 8'hFF, 8'h00, 8'hFF, 16'hAAAA, 16'h5555}));
      send(fb_req({8'h00, 8'h01, 8'hFE, 8'h02, 16'h5555, 16'hAAAA}));
      send(rd_req(8'd0));
      send(rd_req(8'd1));
      send(rd_req(8'd20));
      // Fill to overflow with distinct pages of textures 0 and 254 at mip 8.
      for (int i = 0; i < 100; i++)
         send(fb_req({8'hFE, 8'h00, 8'h00, 8'h08, 16'(i * 7) << 8, 16'(i) << 8}));
      send(rd_req(8'd255));
      send(pin_req(8'd0, 5'd2));
      send(fb_req({8'h00, 8'h00, 8'h00, 8'h00, 16'h0F0F, 16'hF0F0}));
      send(rd_req(8'd128));
      rq = '0;
      rq.action = ACT_CLEAR;
      send(rq);
      send(rd_req(8'd0));
      idle(3);

      // Random: bursts with gaps.
      while (n_transfers < 950) begin
         burst = $urandom_range(1, 20);
         repeat (burst) send(rand_request());
         if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 40));
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Covered %0d transfers: pin loads, feedback walks, table overflow, reads, clears.",
               n_transfers);
      if (fail_count == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #400_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
